// File: hdl/pva_pkg.sv
package pva_pkg;

  localparam int ROM_SIZE  = 36;
  localparam int BANK_SIZE = 8;

  localparam int OP_W    = 2;
  localparam int KEY_W   = 8;
  localparam int NOTE_W  = 6;
  localparam int CH_W    = 3;
  localparam int FREQ_W  = 10;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  localparam int CHANNEL_BASE_DEF  = 0;
  localparam int CHANNEL_COUNT_DEF = 4;
  localparam int NOTE_COUNT_DEF    = 36;

  localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd0;
  localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP_ALL = 2'd2;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STOP  = 1'b1;

  typedef struct packed {
    logic              hit;
    logic [NOTE_W-1:0] note;
  } note_lookup_t;

  // Reverse map of the key ROM: key code to note number.
  function automatic note_lookup_t key_to_note(input logic [KEY_W-1:0] key);
    note_lookup_t r;
    r.hit  = 1'b1;
    r.note = '0;
    case (key)
      "z": r.note = 6'd0;
      "x": r.note = 6'd1;
      "c": r.note = 6'd2;
      "v": r.note = 6'd3;
      "b": r.note = 6'd4;
      "n": r.note = 6'd5;
      "m": r.note = 6'd6;
      "a": r.note = 6'd7;
      "s": r.note = 6'd8;
      "d": r.note = 6'd9;
      "f": r.note = 6'd10;
      "g": r.note = 6'd11;
      "h": r.note = 6'd12;
      "j": r.note = 6'd13;
      "k": r.note = 6'd14;
      "l": r.note = 6'd15;
      "q": r.note = 6'd16;
      "w": r.note = 6'd17;
      "e": r.note = 6'd18;
      "r": r.note = 6'd19;
      "t": r.note = 6'd20;
      "y": r.note = 6'd21;
      "u": r.note = 6'd22;
      "i": r.note = 6'd23;
      "o": r.note = 6'd24;
      "p": r.note = 6'd25;
      "1": r.note = 6'd26;
      "2": r.note = 6'd27;
      "3": r.note = 6'd28;
      "4": r.note = 6'd29;
      "5": r.note = 6'd30;
      "6": r.note = 6'd31;
      "7": r.note = 6'd32;
      "8": r.note = 6'd33;
      "9": r.note = 6'd34;
      "0": r.note = 6'd35;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [FREQ_W-1:0] note_tone_hz(input logic [NOTE_W-1:0] note);
    logic [FREQ_W-1:0] f;
    case (note)
      6'd0:  f = 10'd131;
      6'd1:  f = 10'd139;
      6'd2:  f = 10'd147;
      6'd3:  f = 10'd156;
      6'd4:  f = 10'd165;
      6'd5:  f = 10'd175;
      6'd6:  f = 10'd185;
      6'd7:  f = 10'd196;
      6'd8:  f = 10'd208;
      6'd9:  f = 10'd220;
      6'd10: f = 10'd233;
      6'd11: f = 10'd247;
      6'd12: f = 10'd262;
      6'd13: f = 10'd277;
      6'd14: f = 10'd294;
      6'd15: f = 10'd311;
      6'd16: f = 10'd330;
      6'd17: f = 10'd349;
      6'd18: f = 10'd370;
      6'd19: f = 10'd392;
      6'd20: f = 10'd415;
      6'd21: f = 10'd440;
      6'd22: f = 10'd466;
      6'd23: f = 10'd494;
      6'd24: f = 10'd523;
      6'd25: f = 10'd554;
      6'd26: f = 10'd587;
      6'd27: f = 10'd622;
      6'd28: f = 10'd659;
      6'd29: f = 10'd698;
      6'd30: f = 10'd740;
      6'd31: f = 10'd784;
      6'd32: f = 10'd831;
      6'd33: f = 10'd880;
      6'd34: f = 10'd932;
      6'd35: f = 10'd988;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

// File: hdl/poly_voice_allocator_core.sv
// Operation: a request is taken only while the block is idle, then the channel window is
// scanned one channel per cycle; no new request is taken until the last one is done.
// An ignored request leaves the block idle; a voice steal takes the longest.
// Stalls on the result side hold the scan, since the single result register sends one
// result per cycle at most.
// Reset (rst_n low, synchronous): every channel is freed, no result is pending and the
// block returns to idle, ready for a request.
module poly_voice_allocator_core
  import pva_pkg::*;
#(
  parameter int CHANNEL_BASE  = CHANNEL_BASE_DEF,
  parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF,
  parameter int NOTE_COUNT    = NOTE_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] key
  input  logic [OP_W-1:0]       in_tuser,   // [1:0] operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [2:0] channel, [12:3] frequency, [15:13] zero
  output logic                  out_tuser,  // [0] command
  output logic                  out_tlast
);

  // The channel window is clipped at the end of the bank, and only the ROM notes exist.
  localparam int END_RAW    = CHANNEL_BASE + CHANNEL_COUNT;
  localparam int END_CH     = (END_RAW < BANK_SIZE) ? END_RAW : BANK_SIZE;
  localparam int NOTES_USED = (NOTE_COUNT < ROM_SIZE) ? NOTE_COUNT : ROM_SIZE;
  localparam logic [CH_W-1:0]   BASE_CH  = CH_W'(CHANNEL_BASE);
  localparam logic [CH_W-1:0]   LAST_CH  = CH_W'(END_CH - 1);
  localparam logic [NOTE_W:0]   NOTE_LIM = (NOTE_W+1)'(NOTES_USED);

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_STEAL = 2'd2;
  localparam logic [1:0] S_START = 2'd3;

  logic [1:0]        st_r, st_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [NOTE_W-1:0] tag_r, tag_nxt;     // note number plus one, as held per channel
  logic [NOTE_W-1:0] note_r, note_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;       // channel under scan
  logic [CH_W-1:0]   tgt_r, tgt_nxt;     // channel picked for the start
  logic              free_r, free_nxt;   // a free channel was seen during the scan

  // Channel table: zero means free, otherwise note number plus one.
  logic [NOTE_W-1:0] chan_note_r [BANK_SIZE];

  logic              out_vld_r, out_vld_nxt;
  logic              out_cmd_r, out_cmd_nxt;
  logic [CH_W-1:0]   out_ch_r, out_ch_nxt;
  logic [FREQ_W-1:0] out_freq_r, out_freq_nxt;
  logic              out_last_r, out_last_nxt;

  logic              tbl_we;
  logic [CH_W-1:0]   tbl_wa;
  logic [NOTE_W-1:0] tbl_wd;

  note_lookup_t      lk;
  logic              map_ok;
  logic              out_free;
  logic [NOTE_W-1:0] cur;
  logic              busy_above;

  assign lk       = key_to_note(in_tdata);
  assign map_ok   = lk.hit && ({1'b0, lk.note} < NOTE_LIM);
  assign out_free = !out_vld_r || out_tready;
  assign cur      = chan_note_r[ch_r];
  assign in_tready = (st_r == S_IDLE);

  // Is any channel above the one under scan still busy? Decides tlast for stop all.
  always_comb begin
    busy_above = 1'b0;
    for (int i = 0; i < BANK_SIZE; i++) begin
      if ((CH_W'(i) > ch_r) && (CH_W'(i) <= LAST_CH) && (chan_note_r[i] != '0)) begin
        busy_above = 1'b1;
      end
    end
  end

  always_comb begin
    st_nxt       = st_r;
    op_nxt       = op_r;
    tag_nxt      = tag_r;
    note_nxt     = note_r;
    ch_nxt       = ch_r;
    tgt_nxt      = tgt_r;
    free_nxt     = free_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_cmd_nxt  = out_cmd_r;
    out_ch_nxt   = out_ch_r;
    out_freq_nxt = out_freq_r;
    out_last_nxt = out_last_r;
    tbl_we       = 1'b0;
    tbl_wa       = ch_r;
    tbl_wd       = '0;

    case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt   = in_tuser;
          note_nxt = lk.note;
          tag_nxt  = lk.note + NOTE_W'(1);
          ch_nxt   = BASE_CH;
          free_nxt = 1'b0;
          // Unmapped keys and the unused operation code produce nothing.
          if (in_tuser == OP_STOP_ALL ||
              (map_ok && (in_tuser == OP_NOTE_ON || in_tuser == OP_NOTE_OFF))) begin
            st_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        case (op_r)
          OP_NOTE_ON: begin
            if (cur == tag_r) begin
              st_nxt = S_IDLE;                  // already sounding
            end else begin
              if (cur == '0 && !free_r) begin
                free_nxt = 1'b1;
                tgt_nxt  = ch_r;
              end
              if (ch_r == LAST_CH) begin
                st_nxt = (free_r || cur == '0) ? S_START : S_STEAL;
                if (!(free_r || cur == '0)) begin
                  tgt_nxt = BASE_CH;
                end
              end else begin
                ch_nxt = ch_r + CH_W'(1);
              end
            end
          end
          OP_NOTE_OFF: begin
            if (cur == tag_r) begin
              if (out_free) begin
                out_vld_nxt  = 1'b1;
                out_cmd_nxt  = CMD_STOP;
                out_ch_nxt   = ch_r;
                out_freq_nxt = '0;
                out_last_nxt = 1'b1;
                tbl_we       = 1'b1;
                st_nxt       = S_IDLE;
              end
            end else if (ch_r == LAST_CH) begin
              st_nxt = S_IDLE;                  // note was silent
            end else begin
              ch_nxt = ch_r + CH_W'(1);
            end
          end
          default: begin                        // stop all
            if (cur != '0) begin
              if (out_free) begin
                out_vld_nxt  = 1'b1;
                out_cmd_nxt  = CMD_STOP;
                out_ch_nxt   = ch_r;
                out_freq_nxt = '0;
                out_last_nxt = !busy_above;
                tbl_we       = 1'b1;
                if (!busy_above || ch_r == LAST_CH) begin
                  st_nxt = S_IDLE;
                end else begin
                  ch_nxt = ch_r + CH_W'(1);
                end
              end
            end else if (ch_r == LAST_CH) begin
              st_nxt = S_IDLE;
            end else begin
              ch_nxt = ch_r + CH_W'(1);
            end
          end
        endcase
      end

      S_STEAL: begin
        // Every channel is busy: the lowest one of the window gives up its note.
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_cmd_nxt  = CMD_STOP;
          out_ch_nxt   = BASE_CH;
          out_freq_nxt = '0;
          out_last_nxt = 1'b0;
          tbl_we       = 1'b1;
          tbl_wa       = BASE_CH;
          st_nxt       = S_START;
        end
      end

      S_START: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_cmd_nxt  = CMD_START;
          out_ch_nxt   = tgt_r;
          out_freq_nxt = note_tone_hz(note_r);
          out_last_nxt = 1'b1;
          tbl_we       = 1'b1;
          tbl_wa       = tgt_r;
          tbl_wd       = tag_r;
          st_nxt       = S_IDLE;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      out_vld_r <= 1'b0;
      for (int i = 0; i < BANK_SIZE; i++) begin
        chan_note_r[i] <= '0;
      end
    end else begin
      st_r      <= st_nxt;
      out_vld_r <= out_vld_nxt;
      if (tbl_we) begin
        chan_note_r[tbl_wa] <= tbl_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    tag_r      <= tag_nxt;
    note_r     <= note_nxt;
    ch_r       <= ch_nxt;
    tgt_r      <= tgt_nxt;
    free_r     <= free_nxt;
    out_cmd_r  <= out_cmd_nxt;
    out_ch_r   <= out_ch_nxt;
    out_freq_r <= out_freq_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_cmd_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(OUT_DATA_W - FREQ_W - CH_W)'(0), out_freq_r, out_ch_r};

  // A start always carries a real tone, a stop never does.
  ast_start_has_freq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_cmd_r == CMD_START) |-> (out_freq_r != '0))
    else $error("start result without a frequency");

  ast_stop_no_freq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_cmd_r == CMD_STOP) |-> (out_freq_r == '0))
    else $error("stop result with a frequency");

  // Results only address channels inside the window.
  ast_channel_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_ch_r >= BASE_CH && out_ch_r <= LAST_CH))
    else $error("result addresses a channel outside the window");

  // After a start, the channel it names holds a note.
  ast_start_claims: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_START && out_free) |=> (chan_note_r[out_ch_r] != '0))
    else $error("started channel not marked busy");

endmodule

// File: sim/poly_voice_allocator_core_test.sv
`timescale 1ns / 100ps

module poly_voice_allocator_core_test;
  import pva_pkg::*;

  // The block is built with its default voice window; the scoreboard uses the same values.
  localparam int WIN_BASE   = CHANNEL_BASE_DEF;
  localparam int WIN_COUNT  = CHANNEL_COUNT_DEF;
  localparam int NOTES_LIVE = NOTE_COUNT_DEF;
  localparam int WIN_END    = (WIN_BASE + WIN_COUNT < BANK_SIZE) ? WIN_BASE + WIN_COUNT
                                                                  : BANK_SIZE;
  localparam int NOTES_USED = (NOTES_LIVE < ROM_SIZE) ? NOTES_LIVE : ROM_SIZE;

  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  // Keyboard layout, lowest note first: the first character sits in the top byte.
  localparam logic [8*ROM_SIZE-1:0] KEY_ORDER = "zxcvbnmasdfghjklqwertyuiop1234567890";
  localparam logic [FREQ_W-1:0] TONE_HZ [0:ROM_SIZE-1] = '{
    10'd131, 10'd139, 10'd147, 10'd156, 10'd165, 10'd175, 10'd185,
    10'd196, 10'd208, 10'd220, 10'd233, 10'd247, 10'd262, 10'd277, 10'd294, 10'd311,
    10'd330, 10'd349, 10'd370, 10'd392, 10'd415, 10'd440, 10'd466, 10'd494, 10'd523,
    10'd554, 10'd587, 10'd622, 10'd659, 10'd698, 10'd740, 10'd784, 10'd831, 10'd880,
    10'd932, 10'd988
  };

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
  } key_event_t;

  typedef struct packed {
    logic              cmd;
    logic [CH_W-1:0]   ch;
    logic [FREQ_W-1:0] freq;
    logic              last;
  } voice_cmd_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [7:0] key
  logic [OP_W-1:0]       in_tuser = '0;   // [1:0] operation
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [2:0] channel, [12:3] frequency, [15:13] zero
  logic                  out_tuser;       // [0] command
  logic                  out_tlast;

  poly_voice_allocator_core #(
    .CHANNEL_BASE  (WIN_BASE),
    .CHANNEL_COUNT (WIN_COUNT),
    .NOTE_COUNT    (NOTES_LIVE)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  key_event_t key_events[$];
  voice_cmd_t expected_cmds[$];

  // Scoreboard copy of the allocation tables.
  logic [NOTE_W-1:0] chan_note [BANK_SIZE];
  logic [3:0]        note_chan [ROM_SIZE];

  int  errors = 0;
  int  requests_taken = 0;
  int  cmds_checked = 0;
  int  steals = 0;
  bit  req_taken = 1'b0;

  function automatic logic [KEY_W-1:0] rom_key(input int idx);
    return KEY_ORDER[8*(ROM_SIZE-1-idx) +: 8];
  endfunction

  function automatic int lookup_note(input logic [KEY_W-1:0] key);
    for (int i = 0; i < NOTES_USED; i++) begin
      if (rom_key(i) == key) return i;
    end
    return -1;
  endfunction

  function automatic voice_cmd_t make_cmd(input logic cmd, input int ch,
                                          input logic [FREQ_W-1:0] freq);
    voice_cmd_t v;
    v.cmd  = cmd;
    v.ch   = ch[CH_W-1:0];
    v.freq = freq;
    v.last = 1'b0;
    return v;
  endfunction

  task automatic free_channel(input int ch);
    if (chan_note[ch] != 0) note_chan[chan_note[ch] - 1] = '0;
    chan_note[ch] = '0;
  endtask

  // Works out the tone commands that one accepted request produces and queues them.
  task automatic allocate_voices(input key_event_t ev);
    voice_cmd_t burst[$];
    int note;
    int ch;
    bit found;
    note = lookup_note(ev.key);
    case (ev.op)
      OP_NOTE_ON: begin
        if (note >= 0 && !note_chan[note][3]) begin
          ch = WIN_BASE;
          found = 1'b0;
          for (int c = WIN_BASE; c < WIN_END; c++) begin
            if (!found && chan_note[c] == 0) begin
              ch = c;
              found = 1'b1;
            end
          end
          // Every voice busy: the lowest voice of the window is taken over.
          if (!found) begin
            free_channel(ch);
            burst.push_back(make_cmd(CMD_STOP, ch, '0));
            steals++;
          end
          chan_note[ch] = NOTE_W'(note + 1);
          note_chan[note] = {1'b1, ch[CH_W-1:0]};
          burst.push_back(make_cmd(CMD_START, ch, TONE_HZ[note]));
        end
      end
      OP_NOTE_OFF: begin
        if (note >= 0 && note_chan[note][3]) begin
          ch = int'(note_chan[note][CH_W-1:0]);
          burst.push_back(make_cmd(CMD_STOP, ch, '0));
          chan_note[ch] = '0;
          note_chan[note] = '0;
        end
      end
      OP_STOP_ALL: begin
        for (int c = WIN_BASE; c < WIN_END; c++) begin
          if (chan_note[c] != 0) begin
            burst.push_back(make_cmd(CMD_STOP, c, '0));
            free_channel(c);
          end
        end
      end
      default: ;
    endcase
    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) expected_cmds.push_back(burst[i]);
  endtask

  // Request driver: bursts of back-to-back requests separated by random idle gaps, some of them empty.
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    logic       nxt_valid;
    key_event_t ev;
    nxt_valid = in_tvalid;
    if (rst_n) begin
      if (in_tvalid && !req_taken) begin
        nxt_valid = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        nxt_valid = 1'b0;
      end else if (key_events.size() > 0) begin
        ev = key_events.pop_front();
        nxt_valid = 1'b1;
        in_tdata <= ev.key;
        in_tuser <= ev.op;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        nxt_valid = 1'b0;
      end
    end
    in_tvalid <= nxt_valid;
  end

  // Result sink: the stall pattern steps with rx_phase[8:6], from always ready
  // through random and periodic stalls.
  logic [8:0] rx_phase = '0;

  always @(negedge clk) begin
    logic rdy;
    rx_phase <= rx_phase + 1'b1;
    case (rx_phase[8:6])
      3'd0, 3'd1: rdy = 1'b1;
      3'd2:       rdy = ($urandom_range(0, 1) != 0);
      3'd3:       rdy = (rx_phase[1:0] == 2'd0);
      3'd4:       rdy = rx_phase[3];
      3'd5:       rdy = ($urandom_range(0, 7) != 0);
      3'd6:       rdy = (rx_phase[2:0] == 3'd7);
      default:    rdy = $urandom_range(0, 3) != 0;
    endcase
    out_tready <= rst_n ? rdy : 1'b0;
  end

  // Monitor: requests are predicted first, then any result leaving this edge is checked.
  always @(posedge clk) begin
    voice_cmd_t exp_cmd;
    req_taken = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        req_taken = 1'b1;
        requests_taken++;
        allocate_voices('{op: in_tuser, key: in_tdata});
      end
      if (out_tvalid && out_tready) begin
        if (expected_cmds.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual cmd=%0d ch=%0d freq=%0d last=%0d",
                   $time, out_tuser, out_tdata[2:0], out_tdata[12:3], out_tlast);
          errors++;
        end else begin
          exp_cmd = expected_cmds.pop_front();
          cmds_checked++;
          if (out_tuser !== exp_cmd.cmd) begin
            $display("%0t: command mismatch, expected %0d, actual %0d", $time,
                     exp_cmd.cmd, out_tuser);
            errors++;
          end
          if (out_tdata[2:0] !== exp_cmd.ch) begin
            $display("%0t: channel mismatch, expected %0d, actual %0d", $time,
                     exp_cmd.ch, out_tdata[2:0]);
            errors++;
          end
          if (out_tdata[12:3] !== exp_cmd.freq) begin
            $display("%0t: frequency mismatch, expected %0d, actual %0d", $time,
                     exp_cmd.freq, out_tdata[12:3]);
            errors++;
          end
          if (out_tlast !== exp_cmd.last) begin
            $display("%0t: last mismatch, expected %0d, actual %0d", $time,
                     exp_cmd.last, out_tlast);
            errors++;
          end
          if (out_tdata[15:13] !== 3'b000) begin
            $display("%0t: padding mismatch, expected 0, actual %0d", $time,
                     out_tdata[15:13]);
            errors++;
          end
        end
      end
    end
  end

  task automatic queue_event(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
    key_events.push_back('{op: op, key: key});
  endtask

  // Random keys favor the lowest eight notes so note on and note off meet often.
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 4) != 0) return rom_key($urandom_range(0, 7));
    return rom_key($urandom_range(0, ROM_SIZE-1));
  endfunction

  initial begin
    int sel;
    foreach (chan_note[i]) chan_note[i] = '0;
    foreach (note_chan[i]) note_chan[i] = '0;

    // Directed part: empty-bank cases, ignored keys, lowest and highest tones,
    // a full bank, voice stealing, and stop all with and without busy voices.
    queue_event(OP_STOP_ALL, "z");
    queue_event(OP_NOTE_OFF, "z");
    queue_event(OP_NOTE_ON, 8'h00);
    queue_event(OP_NOTE_ON, 8'hFF);
    queue_event(OP_RESERVED, "z");
    queue_event(OP_NOTE_ON, "z");
    queue_event(OP_NOTE_ON, "z");
    queue_event(OP_NOTE_ON, "0");
    queue_event(OP_NOTE_ON, "q");
    queue_event(OP_NOTE_ON, "a");
    queue_event(OP_NOTE_ON, "p");
    queue_event(OP_NOTE_OFF, "z");
    queue_event(OP_NOTE_OFF, "q");
    queue_event(OP_NOTE_ON, "m");
    queue_event(OP_STOP_ALL, 8'hFF);
    queue_event(OP_STOP_ALL, 8'h00);
    queue_event(OP_NOTE_ON, "x");
    queue_event(OP_NOTE_OFF, "x");
    queue_event(OP_NOTE_OFF, 8'h7F);
    queue_event(OP_NOTE_ON, "z");
    queue_event(OP_NOTE_ON, "x");
    queue_event(OP_NOTE_ON, "c");
    queue_event(OP_NOTE_ON, "v");
    queue_event(OP_NOTE_ON, "b");
    queue_event(OP_STOP_ALL, "b");

    // Random part: mostly note on and note off requests on mapped keys, with stop all,
    // arbitrary key bytes and the reserved operation mixed in.
    for (int i = 0; i < 445; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50)      queue_event(OP_NOTE_ON, pick_key());
      else if (sel < 80) queue_event(OP_NOTE_OFF, pick_key());
      else if (sel < 88) queue_event(OP_STOP_ALL, KEY_W'($urandom_range(0, 255)));
      else if (sel < 95) queue_event(OP_W'($urandom_range(OP_NOTE_ON, OP_STOP_ALL)),
                                     KEY_W'($urandom_range(0, 255)));
      else               queue_event(OP_RESERVED, KEY_W'($urandom_range(0, 255)));
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (key_events.size() > 0 || in_tvalid || expected_cmds.size() > 0)
      @(posedge clk);
    repeat (WIN_COUNT + 10) @(posedge clk);
    if (expected_cmds.size() > 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_cmds.size());
      errors++;
    end

    $display("Sent %0d key requests and checked %0d tone commands, %0d of them voice steals.",
             requests_taken, cmds_checked, steals);
    if (errors == 0) begin
      $display("PASS poly_voice_allocator_core");
    end else begin
      $display("FAIL poly_voice_allocator_core");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("FAIL poly_voice_allocator_core");
    $finish;
  end

endmodule
